// ----- design/binary_trie_wildcard_match_macros.svh -----
// Assertion macros for the binary trie wildcard match block.
`ifndef BINARY_TRIE_WILDCARD_MATCH_MACROS_SVH
`define BINARY_TRIE_WILDCARD_MATCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BTWM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BTWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/btwm_pkg.sv -----
// Shared constants, node entry layout and controller states for the trie matcher.
package btwm_pkg;

	localparam int MAX_BITS   = 32;
	localparam int KEY_W      = 32;
	localparam int LEN_W      = 6;
	localparam int NODE_COUNT = 4096;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int USED_W     = NODE_W + 1;
	localparam int LEN_LIMIT_I = (MAX_BITS < KEY_W) ? MAX_BITS : KEY_W;

	localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(LEN_LIMIT_I);
	localparam logic [USED_W-1:0] NODES_FULL = USED_W'(NODE_COUNT);
	localparam logic [NODE_W-1:0] ROOT_NODE  = '0;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic              wild;
		logic              exact;
		logic [NODE_W-1:0] one_child;
		logic [NODE_W-1:0] zero_child;
	} node_t;

	localparam int NODE_BITS = $bits(node_t);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_INS,
		ST_LOOK
	} state_t;

endpackage

// ----- design/btwm_ram.sv -----
// Generic single-port RAM with registered read data.
module btwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- design/binary_trie_wildcard_match.sv -----
// Binary trie rule store with wildcard endings: insert and lookup controller.
//
// Usage: drive kind, key, length and wildcard_req and raise start while busy is
// low; the item is taken at that clock edge. kind 0 inserts a rule, kind 1 looks
// up a key. Each item yields one result beat: done is high for exactly one cycle
// with matched and status valid, and the receiver cannot stall it.
// length above 32 is saturated to 32 key bits.
// The walk makes one node memory access per key bit plus a final mark or check
// access, and done rises on the cycle after the final access. The next item
// can be taken in the done cycle. Lookups stop early on a wildcard or a
// missing child. All node state lives in one single-port node memory.
// New nodes are allocated in order and written whole when first touched, so
// only the root entry needs clearing: after reset busy stays high for one
// cycle while the root entry is written to zero. A full node store ends an
// insert with status 1; nodes already added stay, no mark is set.
module binary_trie_wildcard_match
	import btwm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             kind,
	input  logic [KEY_W-1:0] key,
	input  logic [LEN_W-1:0] length,
	input  logic             wildcard_req,
	output logic             done,
	output logic             matched,
	output logic             status
);

	state_t state_q, state_d;

	logic [KEY_W-1:0]  key_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;
	logic [NODE_W-1:0] cur_q;
	logic              wild_q;
	logic              fresh_q;
	logic [USED_W-1:0] nodes_used_q;
	logic              done_q, matched_q, status_q;

	logic                 mem_we;
	logic [NODE_W-1:0]    mem_addr;
	logic [NODE_BITS-1:0] mem_wdata_bits, mem_rdata_bits;
	node_t                mem_wdata;
	node_t                entry;

	logic              accept;
	logic              bit_b;
	logic [NODE_W-1:0] child;
	logic              at_end;
	logic              store_full;
	logic              step, alloc, fin, fin_match, fin_full;
	logic [LEN_W-1:0]  len_sat;

	btwm_ram #(
		.WIDTH(NODE_BITS),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata_bits),
		.rdata (mem_rdata_bits)
	);

	assign mem_wdata_bits = mem_wdata;

	assign accept     = start && (state_q == ST_IDLE);
	assign len_sat    = (length > LEN_LIMIT) ? LEN_LIMIT : length;
	assign entry      = fresh_q ? node_t'('0) : node_t'(mem_rdata_bits);
	assign bit_b      = key_q[KEY_W-1];
	assign child      = bit_b ? entry.one_child : entry.zero_child;
	assign at_end     = (idx_q == len_q);
	assign store_full = (nodes_used_q == NODES_FULL);

	// datapath and memory control
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = ROOT_NODE;
		mem_wdata = entry;
		step      = 1'b0;
		alloc     = 1'b0;
		fin       = 1'b0;
		fin_match = 1'b0;
		fin_full  = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_addr = ROOT_NODE;
			end
			ST_LOOK: begin
				if (entry.wild) begin
					fin       = 1'b1;
					fin_match = 1'b1;
				end else if (at_end) begin
					fin       = 1'b1;
					fin_match = entry.exact && (len_q != '0);
				end else if (child == ROOT_NODE) begin
					fin = 1'b1;
				end else begin
					step     = 1'b1;
					mem_addr = child;
				end
			end
			ST_INS: begin
				mem_addr = cur_q;
				if (at_end) begin
					mem_we = 1'b1;
					fin    = 1'b1;
					if (wild_q) begin
						mem_wdata.wild = 1'b1;
					end else begin
						mem_wdata.exact = 1'b1;
					end
				end else if (child != ROOT_NODE) begin
					step     = 1'b1;
					mem_addr = child;
				end else if (store_full) begin
					fin       = 1'b1;
					fin_full  = 1'b1;
					mem_we    = fresh_q;
					mem_wdata = '0;
				end else begin
					mem_we = 1'b1;
					alloc  = 1'b1;
					if (bit_b) begin
						mem_wdata.one_child = nodes_used_q[NODE_W-1:0];
					end else begin
						mem_wdata.zero_child = nodes_used_q[NODE_W-1:0];
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					state_d = (kind == KIND_LOOKUP) ? ST_LOOK : ST_INS;
				end
			end
			ST_INS, ST_LOOK: begin
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			nodes_used_q <= USED_W'(1);
			done_q       <= 1'b0;
			matched_q    <= 1'b0;
			status_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= fin;
			matched_q <= fin_match;
			status_q  <= fin_full;
			if (alloc) begin
				nodes_used_q <= nodes_used_q + USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= key;
			len_q   <= len_sat;
			wild_q  <= wildcard_req;
			idx_q   <= '0;
			cur_q   <= ROOT_NODE;
			fresh_q <= 1'b0;
		end else if (step || alloc) begin
			key_q   <= {key_q[KEY_W-2:0], 1'b0};
			idx_q   <= idx_q + LEN_W'(1);
			cur_q   <= alloc ? nodes_used_q[NODE_W-1:0] : child;
			fresh_q <= alloc;
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign matched = matched_q;
	assign status  = status_q;

endmodule

// ----- design/btwm_checker.sv -----
// Port-level checker for the trie matcher and its bind to the top level.
`include "binary_trie_wildcard_match_macros.svh"

module btwm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic matched,
	input logic status
);

	`BTWM_ASSERT_NEXT(a_take_sets_busy, start && !busy, busy, "accepted item did not raise busy")
	`BTWM_ASSERT_NEXT(a_single_beat, done, !done, "result beat lasted more than one cycle")
	`BTWM_ASSERT_NOW(a_beat_after_work, done, $past(busy) && !busy, "result beat without prior work")
	`BTWM_ASSERT_NOW(a_flags_exclusive, done, !(matched && status), "match and full flagged together")
	`BTWM_ASSERT_NOW(a_quiet_flags, !done, !matched && !status, "result flags set outside a beat")

endmodule

bind binary_trie_wildcard_match btwm_checker u_btwm_checker (.*);

// ----- tb/tb_binary_trie_wildcard_match.sv -----
// Self-checking testbench for the binary trie wildcard match block.
`timescale 1ns / 100ps

module tb_binary_trie_wildcard_match;
	import btwm_pkg::*;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int POOL_DEPTH   = 256;

	typedef struct {
		logic matched;
		logic status;
	} answer_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
	} rule_t;

	class trie_scoreboard;
		logic [NODE_W-1:0] zero_next [NODE_COUNT];
		logic [NODE_W-1:0] one_next [NODE_COUNT];
		bit wild_at [NODE_COUNT];
		bit exact_at [NODE_COUNT];
		int unsigned nodes_taken;
		answer_t pending_answers[$];
		int unsigned mismatches;
		int unsigned inserts;
		int unsigned lookups;
		int unsigned hits;
		int unsigned full_stops;

		function new();
			foreach (zero_next[i]) begin
				zero_next[i] = '0;
				one_next[i] = '0;
				wild_at[i] = 0;
				exact_at[i] = 0;
			end
			nodes_taken = 1;
			mismatches = 0;
			inserts = 0;
			lookups = 0;
			hits = 0;
			full_stops = 0;
		endfunction

		function void note_beat(logic op, logic [KEY_W-1:0] k, logic [LEN_W-1:0] len,
				logic wild);
			answer_t ans;
			int unsigned walk_len;
			int unsigned cur;
			int unsigned nxt;
			logic b;
			bit consumed;
			ans.matched = 1'b0;
			ans.status = STATUS_OK;
			walk_len = 32'((len > LEN_LIMIT) ? LEN_LIMIT : len);
			cur = 32'(ROOT_NODE);
			if (op == KIND_INSERT) begin
				inserts++;
				for (int i = 0; i < walk_len; i++) begin
					b = k[KEY_W-1-i];
					nxt = 32'(b ? one_next[cur] : zero_next[cur]);
					if (nxt == 0) begin
						if (nodes_taken >= NODE_COUNT) begin
							ans.status = STATUS_FULL;
							break;
						end
						nxt = nodes_taken;
						nodes_taken++;
						zero_next[nxt] = '0;
						one_next[nxt] = '0;
						wild_at[nxt] = 0;
						exact_at[nxt] = 0;
						if (b)
							one_next[cur] = NODE_W'(nxt);
						else
							zero_next[cur] = NODE_W'(nxt);
					end
					cur = nxt;
				end
				if (ans.status == STATUS_FULL)
					full_stops++;
				else if (wild)
					wild_at[cur] = 1;
				else
					exact_at[cur] = 1;
			end else begin
				lookups++;
				ans.matched = wild_at[ROOT_NODE];
				consumed = 0;
				for (int i = 0; i < walk_len && !ans.matched; i++) begin
					b = k[KEY_W-1-i];
					nxt = 32'(b ? one_next[cur] : zero_next[cur]);
					if (nxt == 0)
						break;
					cur = nxt;
					if (wild_at[cur])
						ans.matched = 1'b1;
					else if (i + 1 == walk_len)
						consumed = 1;
				end
				if (!ans.matched && consumed)
					ans.matched = exact_at[cur];
				if (ans.matched)
					hits++;
			end
			pending_answers.push_back(ans);
		endfunction

		function void check_beat(logic m, logic s);
			answer_t want;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with no item outstanding: matched=%0b status=%0b",
						m, s);
				return;
			end
			want = pending_answers.pop_front();
			if (m !== want.matched || s !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected matched=%0b status=%0b, got matched=%0b status=%0b",
						$realtime, want.matched, want.status, m, s);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             kind = KIND_INSERT;
	logic [KEY_W-1:0] key = '0;
	logic [LEN_W-1:0] length = '0;
	logic             wildcard_req = 1'b0;
	logic             done;
	logic             matched;
	logic             status;

	trie_scoreboard sb = new();
	rule_t rule_pool[$];
	int unsigned sent_items = 0;
	int unsigned cycles = 0;
	bit no_idle = 0;

	binary_trie_wildcard_match u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key(key),
		.length(length),
		.wildcard_req(wildcard_req),
		.done(done),
		.matched(matched),
		.status(status)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_beat(kind, key, length, wildcard_req);
			if (done)
				sb.check_beat(matched, status);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return LEN_W'($urandom_range(0, 12));
		if (r < 88)
			return LEN_W'($urandom_range(13, 32));
		return LEN_W'($urandom_range(33, 63));
	endfunction

	function automatic logic [KEY_W-1:0] prefix_mask(int unsigned n);
		logic [KEY_W-1:0] ones;
		ones = '1;
		return (n == 0) ? '0 : ones << (KEY_W - n);
	endfunction

	// one beat: optional idle, then hold start until the block takes it
	task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
			input logic [LEN_W-1:0] len, input logic wild);
		int unsigned gap;
		rule_t r;
		if (sent_items % 100 == 0)
			no_idle = ($urandom_range(0, 3) == 0);
		sent_items++;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= op;
		key <= k;
		length <= len;
		wildcard_req <= wild;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == KIND_INSERT) begin
			r.key = k;
			r.len = len;
			if (rule_pool.size() < POOL_DEPTH)
				rule_pool.push_back(r);
			else
				rule_pool[$urandom_range(0, POOL_DEPTH - 1)] = r;
		end
	endtask

	task automatic random_insert(input bit long_key);
		logic [KEY_W-1:0] k;
		logic [7:0] lead [4];
		lead[0] = 8'h00;
		lead[1] = 8'hA5;
		lead[2] = 8'hFF;
		lead[3] = 8'h3C;
		k = $urandom;
		if (long_key)
			send_item(KIND_INSERT, k, LEN_W'(32), $urandom_range(0, 3) == 0);
		else begin
			if ($urandom_range(0, 1))
				k[KEY_W-1 -: 8] = lead[$urandom_range(0, 3)];
			send_item(KIND_INSERT, k, pick_len(), $urandom_range(0, 3) == 0);
		end
	endtask

	// mostly keys near known rules so the walk goes deep
	task automatic random_lookup();
		rule_t r;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] m;
		int unsigned n;
		int unsigned v;
		if (rule_pool.size() != 0 && $urandom_range(0, 9) < 7) begin
			r = rule_pool[$urandom_range(0, rule_pool.size() - 1)];
			n = 32'((r.len > LEN_LIMIT) ? LEN_LIMIT : r.len);
			v = $urandom_range(0, 3);
			if (v == 1 && n > 0)
				n = $urandom_range(0, n - 1);
			m = prefix_mask(n);
			k = (r.key & m) | ($urandom & ~m);
			if (v == 2)
				n = $urandom_range(n, 32);
			else if (v == 3 && n > 0)
				k[KEY_W - $urandom_range(1, n)] ^= 1'b1;
			send_item(KIND_LOOKUP, k, LEN_W'(n), 1'($urandom_range(0, 1)));
		end else
			send_item(KIND_LOOKUP, $urandom, pick_len(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, 1'b0);
		send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd32, 1'b1);
		send_item(KIND_INSERT, 32'h0000_0000, 6'd0, 1'b0);
		send_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, 1'b0);
		send_item(KIND_INSERT, 32'hA000_0000, 6'd3, 1'b0);
		send_item(KIND_LOOKUP, 32'hA000_0000, 6'd3, 1'b0);
		send_item(KIND_LOOKUP, 32'hA123_4567, 6'd3, 1'b1);
		send_item(KIND_LOOKUP, 32'hA000_0000, 6'd2, 1'b0);
		send_item(KIND_LOOKUP, 32'hA000_0000, 6'd4, 1'b0);
		send_item(KIND_INSERT, 32'hFF00_0000, 6'd8, 1'b1);
		send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd32, 1'b0);
		send_item(KIND_LOOKUP, 32'hFF00_0000, 6'd63, 1'b0);
		send_item(KIND_INSERT, 32'h1234_5678, 6'd63, 1'b0);
		send_item(KIND_LOOKUP, 32'h1234_5678, 6'd32, 1'b0);
		send_item(KIND_LOOKUP, 32'h1234_5678, 6'd40, 1'b0);
		send_item(KIND_LOOKUP, 32'h1234_5679, 6'd32, 1'b0);
		send_item(KIND_LOOKUP, 32'h1234_5678, 6'd31, 1'b0);
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b0);
		send_item(KIND_INSERT, 32'hA000_0000, 6'd3, 1'b1);
		send_item(KIND_LOOKUP, 32'hA000_0000, 6'd20, 1'b0);
		send_item(KIND_INSERT, 32'h0000_0000, 6'd32, 1'b1);
		send_item(KIND_LOOKUP, 32'h0000_0000, 6'd33, 1'b0);
		send_item(KIND_LOOKUP, 32'h5555_5555, 6'd32, 1'b1);

		repeat (700) begin
			if ($urandom_range(0, 9) < 4)
				random_insert(0);
			else
				random_lookup();
		end
		// long distinct keys until the node store runs out
		repeat (220) begin
			if ($urandom_range(0, 4) == 0)
				random_lookup();
			else
				random_insert(1);
		end
		repeat (280) begin
			if ($urandom_range(0, 9) < 4)
				random_insert(1'($urandom_range(0, 1)));
			else
				random_lookup();
		end

		// wildcard at the root matches everything from here on
		send_item(KIND_INSERT, $urandom, 6'd0, 1'b1);
		send_item(KIND_LOOKUP, $urandom, 6'd0, 1'b0);
		send_item(KIND_LOOKUP, $urandom, 6'd63, 1'b1);
		send_item(KIND_LOOKUP, $urandom, pick_len(), 1'b0);
		start <= 1'b0;

		while (sb.pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d inserts (%0d stopped on a full store, %0d nodes in use)",
			sb.inserts, sb.full_stops, sb.nodes_taken);
		$display("and %0d lookups (%0d matched); %0d mismatches",
			sb.lookups, sb.hits, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/btwm_pkg.sv
design/btwm_ram.sv
design/binary_trie_wildcard_match.sv
design/btwm_checker.sv
tb/tb_binary_trie_wildcard_match.sv
